FILE: hdl/bdq_pkg.sv
// Shared types and constants for the bounded deque.
// Operation and status codes plus fixed port field widths; no dependencies.
package bdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READ       = 3'd4,
    FN_WRITE      = 3'd5,
    FN_CLEAR      = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

FILE: hdl/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bounded_deque.sv
// Bounded deque: circular buffer in one RAM, front pointer and count in flops.
// Push, write, clear, unused codes and any failed operation: result registered in
// the cycle after the input transfer, one item per cycle while out_ready is high.
// Pop or read that succeeds: data passes the RAM's registered read port, then the
// output register, via state S_READ; no new input is accepted while in S_READ.
// Reset clears state, valid, front, count, not RAM words. Uses bdq_pkg, bdq_ram.
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic [POS_W-1:0]           in_position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  out_read_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic [OCC_W-1:0]           out_occupancy,
  output logic                       out_list_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW:0]   DEPTH_S = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_rv_r, out_rv_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic                accept;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [VALUE_W-1:0]  value_u;
  logic                is_full, is_empty, pos_bad;
  logic                do_read;
  logic [AW-1:0]       slot_back, slot_last, slot_pos, slot_next, front_dec;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  assign accept  = in_valid && in_ready;
  assign value_u = in_value;
  assign is_full  = (count_r >= DEPTH_C);
  assign is_empty = (count_r == '0);
  assign pos_bad  = (KW'(in_position) >= KW'(count_r));

  assign slot_back = slot_of(front_r, count_r[AW-1:0]);
  assign slot_last = slot_of(front_r, AW'(count_r - CW'(1)));
  assign slot_pos  = slot_of(front_r, AW'(in_position));
  assign slot_next = slot_of(front_r, AW'(1));
  assign front_dec = (front_r == '0) ? LAST_A : front_r - AW'(1);

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rv_nxt     = out_rv_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    out_empty_nxt  = out_empty_r;
    ram_we         = 1'b0;
    ram_waddr      = slot_pos;
    ram_wdata      = DATA_WIDTH'(value_u);
    ram_raddr      = slot_pos;
    do_read        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_OK;
          unique case (func_t'(in_func))
            FN_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            FN_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_back;
                count_nxt = count_r + CW'(1);
              end
            end
            FN_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                do_read   = 1'b1;
                ram_raddr = front_r;
                front_nxt = slot_next;
                count_nxt = count_r - CW'(1);
              end
            end
            FN_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                do_read   = 1'b1;
                ram_raddr = slot_last;
                count_nxt = count_r - CW'(1);
              end
            end
            FN_READ: begin
              if (pos_bad) begin
                out_status_nxt = ST_RANGE;
              end else begin
                do_read = 1'b1;
              end
            end
            FN_WRITE: begin
              if (pos_bad) begin
                out_status_nxt = ST_RANGE;
              end else begin
                ram_we = 1'b1;
              end
            end
            FN_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            default: ;
          endcase
          out_rv_nxt    = '0;
          out_occ_nxt   = OCC_W'(count_nxt);
          out_empty_nxt = (count_nxt == '0);
          if (do_read) begin
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        out_rv_nxt    = VALUE_W'(ram_rdata);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rv_r     <= out_rv_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_status     = out_status_r;
  assign out_occupancy  = out_occ_r;
  assign out_list_empty = out_empty_r;

endmodule
